// ----- sv/qbc_pkg.sv -----
// qbc_pkg: shared widths, types and helpers for the box corner unit.
// No dependencies.
package qbc_pkg;

    localparam int CW     = 31;   // centre coordinate width
    localparam int QW     = 16;   // quaternion component width
    localparam int EW     = 20;   // box extent width
    localparam int PRW    = 32;   // 16x16 product width
    localparam int RW     = 34;   // rotation numerator width
    localparam int SW     = 33;   // norm-squared width
    localparam int DW     = SW + 1;   // divisor 2s width
    localparam int NW     = RW + EW + 1;  // numerator width
    localparam int MW     = NW - 1;   // rounded magnitude width
    localparam int QBITS  = 21;   // quotient bits, |offset| < 2^21
    localparam int OW     = 32;   // output coordinate width
    localparam int NCORN  = 4;
    localparam int NLANE  = 2 * NCORN;

    // bit k set: corner k uses the negative half extent
    localparam logic [NCORN-1:0] CORNER_SX_NEG = 4'b1100;
    localparam logic [NCORN-1:0] CORNER_SY_NEG = 4'b0110;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [7:0]           cls;
        logic [15:0]          score;
    } side_t;

    typedef struct packed {
        logic [EW-1:0] l;
        logic [EW-1:0] w;
        logic [EW-1:0] h;
    } dims_t;

    typedef struct packed {
        logic signed [RW-1:0] r00;
        logic signed [RW-1:0] r01;
        logic signed [RW-1:0] r02;
        logic signed [RW-1:0] r10;
        logic signed [RW-1:0] r11;
        logic signed [RW-1:0] r12;
        logic [SW-1:0]        s;
    } matrix_t;

    typedef logic [MW-1:0]    mag_t;
    typedef logic [QBITS-1:0] quo_t;

    function automatic logic signed [OW-1:0] sat32(input logic signed [OW:0] v);
        logic signed [OW-1:0] r;
        if (v[OW] != v[OW-1])
        begin
            r = v[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
        else
        begin
            r = v[OW-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/qbc_box_if.sv -----
// qbc_box_if: input channel, one box item per handshake.
// Depends on qbc_pkg.
interface qbc_box_if;
    import qbc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic [EW-1:0]        box_width;
    logic [EW-1:0]        box_length;
    logic [EW-1:0]        box_height;
    logic [7:0]           class_label;
    logic [15:0]          score_in;

    modport source(output valid, center_x, center_y, quat_w, quat_x, quat_y, quat_z,
                   box_width, box_length, box_height, class_label, score_in,
                   input ready);
    modport sink(input valid, center_x, center_y, quat_w, quat_x, quat_y, quat_z,
                 box_width, box_length, box_height, class_label, score_in,
                 output ready);
endinterface

// ----- sv/qbc_corner_if.sv -----
// qbc_corner_if: output channel, four corner x/y pairs plus pass-through.
// Depends on qbc_pkg.
interface qbc_corner_if;
    import qbc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] corner0_x;
    logic signed [OW-1:0] corner0_y;
    logic signed [OW-1:0] corner1_x;
    logic signed [OW-1:0] corner1_y;
    logic signed [OW-1:0] corner2_x;
    logic signed [OW-1:0] corner2_y;
    logic signed [OW-1:0] corner3_x;
    logic signed [OW-1:0] corner3_y;
    logic [7:0]           class_out;
    logic [15:0]          score_out;

    modport source(output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                   corner2_x, corner2_y, corner3_x, corner3_y, class_out, score_out,
                   input ready);
    modport sink(input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                 corner2_x, corner2_y, corner3_x, corner3_y, class_out, score_out,
                 output ready);
endinterface

// ----- sv/qbc_matrix.sv -----
// qbc_matrix: quaternion products and rotation numerators, two stages.
// Depends on qbc_pkg.
module qbc_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [qbc_pkg::QW-1:0] qw,
    input  logic signed [qbc_pkg::QW-1:0] qx,
    input  logic signed [qbc_pkg::QW-1:0] qy,
    input  logic signed [qbc_pkg::QW-1:0] qz,
    input  qbc_pkg::side_t                side_in,
    input  qbc_pkg::dims_t                dims_in,
    output logic                          out_valid,
    output qbc_pkg::matrix_t              mat,
    output qbc_pkg::side_t                side_out,
    output qbc_pkg::dims_t                dims_out
);
    import qbc_pkg::*;

    logic [1:0] valid_reg;
    logic signed [PRW-1:0] x2_reg, y2_reg, z2_reg, w2_reg;
    logic signed [PRW-1:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    side_t   side1_reg, side2_reg;
    dims_t   dims1_reg, dims2_reg;
    matrix_t mat_reg, mat_next;

    logic signed [RW-1:0] ex2, ey2, ez2, ew2, exy, ezw, exz, eyw, eyz, exw, s_sum;

    always_comb
    begin
        ex2 = RW'(x2_reg);
        ey2 = RW'(y2_reg);
        ez2 = RW'(z2_reg);
        ew2 = RW'(w2_reg);
        exy = RW'(xy_reg);
        ezw = RW'(zw_reg);
        exz = RW'(xz_reg);
        eyw = RW'(yw_reg);
        eyz = RW'(yz_reg);
        exw = RW'(xw_reg);
        s_sum = ex2 + ey2 + ez2 + ew2;
        mat_next.r00 = ex2 - ey2 - ez2 + ew2;
        mat_next.r01 = (exy - ezw) <<< 1;
        mat_next.r02 = (exz + eyw) <<< 1;
        mat_next.r10 = (exy + ezw) <<< 1;
        mat_next.r11 = ey2 - ex2 - ez2 + ew2;
        mat_next.r12 = (eyz - exw) <<< 1;
        mat_next.s   = s_sum[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2_reg    <= qx * qx;
            y2_reg    <= qy * qy;
            z2_reg    <= qz * qz;
            w2_reg    <= qw * qw;
            xy_reg    <= qx * qy;
            zw_reg    <= qz * qw;
            xz_reg    <= qx * qz;
            yw_reg    <= qy * qw;
            yz_reg    <= qy * qz;
            xw_reg    <= qx * qw;
            side1_reg <= side_in;
            dims1_reg <= dims_in;
            mat_reg   <= mat_next;
            side2_reg <= side1_reg;
            dims2_reg <= dims1_reg;
        end
    end

    assign out_valid = valid_reg[1];
    assign mat       = mat_reg;
    assign side_out  = side2_reg;
    assign dims_out  = dims2_reg;
endmodule

// ----- sv/qbc_numer.sv -----
// qbc_numer: corner numerators N and rounded magnitudes |N|+s, three stages.
// Depends on qbc_pkg.
module qbc_numer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  qbc_pkg::matrix_t         mat,
    input  qbc_pkg::side_t           side_in,
    input  qbc_pkg::dims_t           dims_in,
    output logic                     out_valid,
    output qbc_pkg::mag_t            mag [qbc_pkg::NLANE],
    output logic [qbc_pkg::NLANE-1:0] neg,
    output logic [qbc_pkg::DW-1:0]   dvsr,
    output logic                     zero,
    output qbc_pkg::side_t           side_out
);
    import qbc_pkg::*;

    logic [2:0] valid_reg;
    // products: [row*3 + column]
    logic signed [NW-1:0] p_reg [6];
    logic signed [NW-1:0] n_reg [NLANE], n_next [NLANE];
    mag_t                 mag_reg [NLANE], mag_next [NLANE];
    logic [NLANE-1:0]     neg_reg, neg_next;
    logic [SW-1:0]        s3_reg, s4_reg, s5_reg;
    side_t                side3_reg, side4_reg, side5_reg;

    logic signed [EW:0] sl, sw_, sh;
    logic signed [NW-1:0] t0, t1, absn;

    assign sl  = $signed({1'b0, dims_in.l});
    assign sw_ = $signed({1'b0, dims_in.w});
    assign sh  = $signed({1'b0, dims_in.h});

    always_comb
    begin
        t0 = '0;
        t1 = '0;
        for (int k = 0; k < NCORN; k++)
        begin
            for (int a = 0; a < 2; a++)
            begin
                t0 = CORNER_SX_NEG[k] ? -p_reg[a*3] : p_reg[a*3];
                t1 = CORNER_SY_NEG[k] ? -p_reg[a*3+1] : p_reg[a*3+1];
                n_next[2*k+a] = t0 + t1 + p_reg[a*3+2];
            end
        end
    end

    always_comb
    begin
        absn = '0;
        for (int j = 0; j < NLANE; j++)
        begin
            absn        = n_reg[j][NW-1] ? -n_reg[j] : n_reg[j];
            neg_next[j] = n_reg[j][NW-1];
            mag_next[j] = absn[MW-1:0] + MW'(s4_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]  <= mat.r00 * sl;
            p_reg[1]  <= mat.r01 * sw_;
            p_reg[2]  <= mat.r02 * sh;
            p_reg[3]  <= mat.r10 * sl;
            p_reg[4]  <= mat.r11 * sw_;
            p_reg[5]  <= mat.r12 * sh;
            s3_reg    <= mat.s;
            side3_reg <= side_in;
            n_reg     <= n_next;
            s4_reg    <= s3_reg;
            side4_reg <= side3_reg;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            s5_reg    <= s4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign mag       = mag_reg;
    assign neg       = neg_reg;
    assign dvsr      = {s5_reg, 1'b0};
    assign zero      = (s5_reg == '0);
    assign side_out  = side5_reg;
endmodule

// ----- sv/qbc_div.sv -----
// qbc_div: restoring divider, one quotient bit per stage, eight lanes.
// Depends on qbc_pkg.
module qbc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  qbc_pkg::mag_t             mag [qbc_pkg::NLANE],
    input  logic [qbc_pkg::NLANE-1:0] neg,
    input  logic [qbc_pkg::DW-1:0]    dvsr,
    input  logic                      zero,
    input  qbc_pkg::side_t            side_in,
    output logic                      out_valid,
    output qbc_pkg::quo_t             quo [qbc_pkg::NLANE],
    output logic [qbc_pkg::NLANE-1:0] neg_out,
    output logic                      zero_out,
    output qbc_pkg::side_t            side_out
);
    import qbc_pkg::*;

    logic [QBITS-1:0] valid_reg;
    mag_t             rem_reg  [QBITS][NLANE];
    mag_t             rem_next [QBITS][NLANE];
    quo_t             q_reg    [QBITS][NLANE];
    quo_t             q_next   [QBITS][NLANE];
    logic [NLANE-1:0] neg_reg  [QBITS];
    logic [DW-1:0]    d_reg    [QBITS];
    logic             zero_reg [QBITS];
    side_t            side_reg [QBITS];

    logic [DW-1:0]    d_cur;
    mag_t             r_cur;
    quo_t             q_cur;
    logic [MW:0]      dsh;

    always_comb
    begin
        d_cur = '0;
        r_cur = '0;
        q_cur = '0;
        dsh   = '0;
        for (int j = 0; j < QBITS; j++)
        begin
            d_cur = (j == 0) ? dvsr : d_reg[j-1];
            dsh   = {{(MW+1-DW){1'b0}}, d_cur} << (QBITS - 1 - j);
            for (int l = 0; l < NLANE; l++)
            begin
                r_cur = (j == 0) ? mag[l] : rem_reg[j-1][l];
                q_cur = (j == 0) ? '0 : q_reg[j-1][l];
                if ({1'b0, r_cur} >= dsh)
                begin
                    rem_next[j][l] = r_cur - dsh[MW-1:0];
                    q_cur[QBITS-1-j] = 1'b1;
                end
                else
                begin
                    rem_next[j][l] = r_cur;
                end
                q_next[j][l] = q_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[QBITS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg     <= rem_next;
            q_reg       <= q_next;
            neg_reg[0]  <= neg;
            d_reg[0]    <= dvsr;
            zero_reg[0] <= zero;
            side_reg[0] <= side_in;
            for (int j = 1; j < QBITS; j++)
            begin
                neg_reg[j]  <= neg_reg[j-1];
                d_reg[j]    <= d_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[QBITS-1];
    assign quo       = q_reg[QBITS-1];
    assign neg_out   = neg_reg[QBITS-1];
    assign zero_out  = zero_reg[QBITS-1];
    assign side_out  = side_reg[QBITS-1];
endmodule

// ----- sv/quat_box_bev_corners_unit.sv -----
// quat_box_bev_corners_unit: bird's-eye corners of an oriented 3D box.
// Depends on qbc_pkg, qbc_box_if, qbc_corner_if, qbc_matrix, qbc_numer, qbc_div.
//
//   channel       dir   payload
//   in_box        in    centre, quaternion, extents, class, score
//   out_corners   out   four corner x/y (1/1024 m), class, score
//
// One box per cycle sustained while the output is not stalled.
// Stages: 2 matrix, 3 numerator, 21 divider (one quotient bit each), 1 output.
// rst_n clears only the valid bits; payload registers are not reset.
// One shared advance enable: the whole pipe holds while the output item waits,
// so a stall loses and repeats nothing.
module quat_box_bev_corners_unit (
    input  logic         clk,
    input  logic         rst_n,
    qbc_box_if.sink      in_box,
    qbc_corner_if.source out_corners
);
    import qbc_pkg::*;

    logic    adv;
    logic    m_valid, n_valid, d_valid;
    matrix_t m_mat;
    side_t   side_in, m_side, n_side, d_side;
    dims_t   dims_in, m_dims;
    mag_t    n_mag [NLANE];
    logic [NLANE-1:0] n_neg, d_neg;
    logic [DW-1:0]    n_dvsr;
    logic             n_zero, d_zero;
    quo_t             d_quo [NLANE];

    logic                 out_valid_reg;
    logic signed [OW-1:0] coord_reg  [NLANE];
    logic signed [OW-1:0] coord_next [NLANE];
    logic [7:0]           cls_reg;
    logic [15:0]          score_reg;
    logic signed [OW:0]   off, base;

    // pipe moves whenever the output register is empty or being drained
    assign adv          = !out_valid_reg || out_corners.ready;
    assign in_box.ready = adv;

    assign side_in = '{cx: in_box.center_x, cy: in_box.center_y,
                       cls: in_box.class_label, score: in_box.score_in};
    assign dims_in = '{l: in_box.box_length, w: in_box.box_width, h: in_box.box_height};

    qbc_matrix u_matrix (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_box.valid),
        .qw(in_box.quat_w), .qx(in_box.quat_x), .qy(in_box.quat_y), .qz(in_box.quat_z),
        .side_in(side_in), .dims_in(dims_in),
        .out_valid(m_valid), .mat(m_mat), .side_out(m_side), .dims_out(m_dims)
    );

    qbc_numer u_numer (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(m_valid),
        .mat(m_mat), .side_in(m_side), .dims_in(m_dims),
        .out_valid(n_valid), .mag(n_mag), .neg(n_neg), .dvsr(n_dvsr),
        .zero(n_zero), .side_out(n_side)
    );

    qbc_div u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(n_valid),
        .mag(n_mag), .neg(n_neg), .dvsr(n_dvsr), .zero(n_zero), .side_in(n_side),
        .out_valid(d_valid), .quo(d_quo), .neg_out(d_neg), .zero_out(d_zero),
        .side_out(d_side)
    );

    // sign back on, centre added; zero quaternion leaves the centre alone
    always_comb
    begin
        off  = '0;
        base = '0;
        for (int j = 0; j < NLANE; j++)
        begin
            off  = $signed({{(OW+1-QBITS){1'b0}}, d_quo[j]});
            off  = d_neg[j] ? -off : off;
            if (d_zero)
            begin
                off = '0;
            end
            base = (j % 2 == 0) ? (OW+1)'(d_side.cx) : (OW+1)'(d_side.cy);
            coord_next[j] = sat32(base + off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coord_reg <= coord_next;
            cls_reg   <= d_side.cls;
            score_reg <= d_side.score;
        end
    end

    assign out_corners.valid     = out_valid_reg;
    assign out_corners.corner0_x = coord_reg[0];
    assign out_corners.corner0_y = coord_reg[1];
    assign out_corners.corner1_x = coord_reg[2];
    assign out_corners.corner1_y = coord_reg[3];
    assign out_corners.corner2_x = coord_reg[4];
    assign out_corners.corner2_y = coord_reg[5];
    assign out_corners.corner3_x = coord_reg[6];
    assign out_corners.corner3_y = coord_reg[7];
    assign out_corners.class_out = cls_reg;
    assign out_corners.score_out = score_reg;

`ifndef NO_ASSERTIONS
    // a waiting result blocks new boxes
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_corners.valid && !out_corners.ready) |-> !in_box.ready)
        else $error("input accepted while output stalled");

    // results only show up on a pipe advance
    a_valid_after_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_corners.valid) |-> $past(adv))
        else $error("output valid rose without advance");

    // zero quaternion: corner 0 x equals centre x
    a_zero_quat_centre: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && d_valid && d_zero) |=>
        (out_corners.corner0_x == $past((OW)'(d_side.cx))))
        else $error("zero quaternion corner differs from centre");
`endif
endmodule
